### hw/rtl/hdsb_pkg.sv
// ----------------------------------------------------------------------------
// hdsb_pkg
// Shared types and codes of the half-duplex serial buffer controller.
// ----------------------------------------------------------------------------
package hdsb_pkg;

  // event codes carried in the op field
  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_RX_BYTE  = 3'd2,
    OP_TX_READY = 3'd3,
    OP_TX_DONE  = 3'd4
  } op_e;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 7;

  typedef struct packed {
    logic [2:0]        op;
    logic [BYTE_W-1:0] data;
    logic              write_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic               write_accepted;
    logic [BYTE_W-1:0]  line_out_data;
    logic               line_out_valid;
    logic               rx_dropped;
    logic               receiver_on;
    logic               transmitter_on;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } out_item_t;

endpackage

### hw/rtl/hdsb_chan_if.sv
// ----------------------------------------------------------------------------
// hdsb_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface hdsb_chan_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);

endinterface

### hw/rtl/hdsb_ram.sv
// ----------------------------------------------------------------------------
// hdsb_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write the entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // register the read, hold it otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/half_duplex_serial_buffer_ctrl_unit.sv
// Path: an accepted item is held in the stage register beside the ring RAM read,
//   then merged into the result register.
// Throughput: one item per cycle; the ring RAMs' registered read port and the
//   stage/result register pair keep every cycle usable while the sink takes.
// Reset: pointers and levels cleared, receiver on, transmitter off, no event
//   armed; ring contents are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// half_duplex_serial_buffer_ctrl_unit
// Transmit and receive rings with line-direction control for a half-duplex
// serial link.
// ----------------------------------------------------------------------------
module half_duplex_serial_buffer_ctrl_unit #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdsb_chan_if.sink   in_i,
  hdsb_chan_if.source out_o
);

  import hdsb_pkg::*;

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);

  // result fields waiting for the RAM read data
  typedef struct packed {
    logic               read_valid;
    logic               write_accepted;
    logic               line_out_valid;
    logic               rx_dropped;
    logic               receiver_on;
    logic               transmitter_on;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } stage_t;

  logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RX_CW-1:0] rx_count_q, rx_count_d;
  logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TX_CW-1:0] tx_count_q, tx_count_d;
  logic             rx_en_q, rx_en_d, tx_en_q, tx_en_d;
  logic             ready_arm_q, ready_arm_d, done_arm_q, done_arm_d;
  logic             sending_q, sending_d;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  logic      in_fire, stage_adv;
  logic      stage_valid_q;
  stage_t    stage_q, stage_d;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign in_fire   = in_i.valid && in_i.ready;
  assign stage_adv = stage_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !stage_valid_q || !out_valid_q || out_o.ready;

  // decode the event and work out the next ring and line state
  always_comb begin
    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    rx_count_d  = rx_count_q;
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    tx_count_d  = tx_count_q;
    rx_en_d     = rx_en_q;
    tx_en_d     = tx_en_q;
    ready_arm_d = ready_arm_q;
    done_arm_d  = done_arm_q;
    sending_d   = sending_q;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    stage_d     = '0;

    unique case (in_i.item.op)
      OP_WRITE: begin
        if (tx_count_q != TX_CW'(TX_DEPTH)) begin
          tx_we      = 1'b1;
          tx_count_d = tx_count_q + TX_CW'(1);
          tx_head_d  = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + TX_AW'(1);
          stage_d.write_accepted = 1'b1;
        end
        if (in_i.item.write_last && !sending_q) begin
          sending_d   = 1'b1;
          rx_en_d     = 1'b0;
          tx_en_d     = 1'b1;
          ready_arm_d = 1'b1;
        end
      end
      OP_READ: begin
        if (rx_count_q != '0) begin
          rx_re      = 1'b1;
          rx_count_d = rx_count_q - RX_CW'(1);
          rx_tail_d  = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + RX_AW'(1);
          stage_d.read_valid = 1'b1;
        end
      end
      OP_RX_BYTE: begin
        if (rx_en_q) begin
          if (rx_count_q == RX_CW'(RX_DEPTH)) begin
            stage_d.rx_dropped = 1'b1;
          end else begin
            rx_we      = 1'b1;
            rx_count_d = rx_count_q + RX_CW'(1);
            rx_head_d  = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + RX_AW'(1);
          end
        end
      end
      OP_TX_READY: begin
        if (ready_arm_q) begin
          if (tx_count_q != '0) begin
            tx_re      = 1'b1;
            tx_count_d = tx_count_q - TX_CW'(1);
            tx_tail_d  = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + TX_AW'(1);
            stage_d.line_out_valid = 1'b1;
          end else begin
            ready_arm_d = 1'b0;
            done_arm_d  = 1'b1;
            sending_d   = 1'b0;
          end
        end
      end
      OP_TX_DONE: begin
        if (done_arm_q && !sending_q) begin
          done_arm_d = 1'b0;
          tx_en_d    = 1'b0;
          rx_en_d    = 1'b1;
          rx_head_d  = '0;
          rx_tail_d  = '0;
          rx_count_d = '0;
        end
      end
      default: begin
      end
    endcase

    stage_d.receiver_on    = rx_en_d;
    stage_d.transmitter_on = tx_en_d;
    stage_d.rx_level       = LEVEL_W'(rx_count_d);
    stage_d.tx_level       = LEVEL_W'(tx_count_d);
  end

  // advance the ring and line state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_count_q  <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_count_q  <= '0;
      rx_en_q     <= 1'b1;
      tx_en_q     <= 1'b0;
      ready_arm_q <= 1'b0;
      done_arm_q  <= 1'b0;
      sending_q   <= 1'b0;
    end else if (in_fire) begin
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      rx_count_q  <= rx_count_d;
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      tx_count_q  <= tx_count_d;
      rx_en_q     <= rx_en_d;
      tx_en_q     <= tx_en_d;
      ready_arm_q <= ready_arm_d;
      done_arm_q  <= done_arm_d;
      sending_q   <= sending_d;
    end
  end

  // receive ring
  hdsb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (in_i.item.data),
    .re_i    (in_fire && rx_re),
    .raddr_i (rx_tail_q),
    .rdata_o (rx_rdata)
  );

  // transmit ring
  hdsb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (in_i.item.data),
    .re_i    (in_fire && tx_re),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  // stage and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        stage_valid_q <= 1'b1;
      end else if (stage_adv) begin
        stage_valid_q <= 1'b0;
      end
      if (stage_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the flags beside the RAM read, then merge the bytes into the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q <= stage_d;
    end
    if (stage_adv) begin
      out_item_q.read_data      <= stage_q.read_valid ? rx_rdata : '0;
      out_item_q.read_valid     <= stage_q.read_valid;
      out_item_q.write_accepted <= stage_q.write_accepted;
      out_item_q.line_out_data  <= stage_q.line_out_valid ? tx_rdata : '0;
      out_item_q.line_out_valid <= stage_q.line_out_valid;
      out_item_q.rx_dropped     <= stage_q.rx_dropped;
      out_item_q.receiver_on    <= stage_q.receiver_on;
      out_item_q.transmitter_on <= stage_q.transmitter_on;
      out_item_q.rx_level       <= stage_q.rx_level;
      out_item_q.tx_level       <= stage_q.tx_level;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule

### hw/rtl/hdsb_checker.sv
// ----------------------------------------------------------------------------
// hdsb_checker
// Port-level checks on the result channel of the serial buffer controller.
// ----------------------------------------------------------------------------
module hdsb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input hdsb_pkg::out_item_t out_item_i
);

  import hdsb_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // line direction is always one way or the other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.receiver_on != out_item_i.transmitter_on)
    else $error("receiver and transmitter not complementary");

  // one event gives at most one kind of outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({out_item_i.read_valid, out_item_i.write_accepted,
                              out_item_i.line_out_valid, out_item_i.rx_dropped}))
    else $error("more than one outcome flag set");

  // bytes are zero unless flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.read_valid |-> out_item_i.read_data == '0)
    else $error("read data without read valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.line_out_valid |-> out_item_i.line_out_data == '0)
    else $error("line data without line valid");

endmodule

bind half_duplex_serial_buffer_ctrl_unit hdsb_checker u_hdsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);
